>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define BSEM_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication out of reset
`define BSEM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/bsem_pkg.sv
// ----------------------------------------------------------------------------
// bsem_pkg
// Constants, codes and payload types of the binary semaphore table.
// ----------------------------------------------------------------------------
package bsem_pkg;

  // Table geometry
  localparam int unsigned SLOTS   = 16;
  localparam int unsigned ID_BITS = 16;

  // Id counter start and saturation value (never handed out)
  localparam logic [ID_BITS-1:0] FIRST_ID = ID_BITS'(1);
  localparam logic [ID_BITS-1:0] ID_MAX   = {ID_BITS{1'b1}};

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_DOWN  = 2'd2,
    FUNC_UP    = 2'd3
  } bsem_func_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BUSY      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_SLOT   = 2'd3
  } bsem_status_t;

  // Request payload
  typedef struct packed {
    bsem_func_t         func;
    logic [ID_BITS-1:0] sem_id;
  } bsem_in_t;

  // Result payload
  typedef struct packed {
    bsem_status_t       status;
    logic [ID_BITS-1:0] new_id;
  } bsem_out_t;

  // Request token handed from cell to cell
  typedef struct packed {
    logic               valid;
    bsem_func_t         func;
    logic [ID_BITS-1:0] sem_id;
    logic [ID_BITS-1:0] alloc_id;  // id an alloc would hand out
    logic               done;      // some cell (or the head) has settled it
    bsem_status_t       status;
  } bsem_tok_t;

endpackage

>>> rtl/binary_semaphore_table_unit.sv
// ----------------------------------------------------------------------------
// binary_semaphore_table_unit
// Table of binary semaphores (alloc, free, try-down, up) built as a row of
// slot cells that a request token walks through, one cell per cycle.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Handshake            Payload
//  in_*        input      in_valid / in_ready  bsem_in_t  (func, sem_id)
//  out_*       output     out_valid/out_ready  bsem_out_t (status, new_id)
//
//  One request at a time: an accepted request walks the SLOTS cells, one per
//  cycle, then is finished into a holding register and moved to the output
//  register; the next request is taken once the finished result has moved
//  to the output register. A waiting result in the output register does
//  not block a new request; only a second finished result waits behind it.
//  Reset (rst_n low, synchronous) empties the table and sets the id counter
//  to its initial value.
//
module binary_semaphore_table_unit
  import bsem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bsem_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bsem_out_t out_data
);

`include "assert_macros.svh"

  logic               busy_r, busy_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  logic               fin_valid_r, fin_valid_nxt;
  bsem_out_t          fin_r, fin_nxt;
  logic               out_valid_r, out_valid_nxt;
  bsem_out_t          out_r, out_nxt;

  bsem_tok_t          tok [SLOTS+1];
  bsem_tok_t          head_tok;
  bsem_tok_t          tail;
  logic [SLOTS-1:0]   chain_vld;
  logic               in_xfer;
  logic               exhausted;
  logic               granted;
  logic               fin_move;

  assign in_ready  = !busy_r;
  assign in_xfer   = in_valid && in_ready;
  assign exhausted = (next_id_r >= ID_MAX);

  // Head token: an alloc with the counter saturated is settled at entry
  always_comb begin
    head_tok.valid    = in_xfer;
    head_tok.func     = in_data.func;
    head_tok.sem_id   = in_data.sem_id;
    head_tok.alloc_id = next_id_r;
    head_tok.done     = (in_data.func == FUNC_ALLOC) && exhausted;
    head_tok.status   = ((in_data.func == FUNC_ALLOC) && exhausted) ? ST_NO_SLOT : ST_DONE;
  end

  assign tok[0] = head_tok;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bsem_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
    assign chain_vld[i] = tok[i+1].valid;
  end

  assign tail = tok[SLOTS];

  // Tail: an unsettled request found no slot or no matching id
  assign granted = tail.valid && (tail.func == FUNC_ALLOC) && tail.done &&
                   (tail.status == ST_DONE);

  always_comb begin
    if (tail.done) begin
      fin_nxt.status = tail.status;
    end else if (tail.func == FUNC_ALLOC) begin
      fin_nxt.status = ST_NO_SLOT;
    end else begin
      fin_nxt.status = ST_NOT_FOUND;
    end
    fin_nxt.new_id = granted ? tail.alloc_id : '0;
  end

  // Id counter moves only on a granted alloc; saturation is caught at entry
  assign next_id_nxt = granted ? next_id_r + ID_BITS'(1) : next_id_r;

  // Finished result to output register
  assign fin_move = fin_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    busy_nxt      = busy_r;
    fin_valid_nxt = fin_valid_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_move) begin
      out_nxt       = fin_r;
      out_valid_nxt = 1'b1;
      fin_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
    if (tail.valid) begin
      fin_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      next_id_r   <= FIRST_ID;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      next_id_r   <= next_id_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      fin_r <= fin_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A request enters only with the row and the holding register empty
  `BSEM_ASSERT_IMPL(a_accept_idle, in_xfer, (chain_vld == '0) && !fin_valid_r, "request taken while busy")
  // At most one request in the row or holding register
  `BSEM_ASSERT(a_single_req, $onehot0({chain_vld, fin_valid_r}), "more than one request in flight")
  // Id counter only steps up by one
  `BSEM_ASSERT_IMPL(a_id_step, next_id_r != $past(next_id_r), next_id_r == $past(next_id_r) + ID_BITS'(1), "id counter jump")
  // A result other than done carries no id
  `BSEM_ASSERT_IMPL(a_out_id, out_valid_r && (out_r.status != ST_DONE), out_r.new_id == '0, "id on failed result")

endmodule

>>> rtl/bsem_cell.sv
// ----------------------------------------------------------------------------
// bsem_cell
// One semaphore slot. Acts on the passing request token and hands the token,
// marked settled when this slot served it, to the next cell through its token register.
// ----------------------------------------------------------------------------
module bsem_cell
  import bsem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bsem_tok_t tok_i,
  output bsem_tok_t tok_o
);

  logic               used_r, used_nxt;
  logic               released_r, released_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  bsem_tok_t          tok_r, tok_nxt;

  logic open_req;
  logic take;
  logic hit;

  // Unsettled request: alloc claims the first unused slot, others match by id
  assign open_req = tok_i.valid && !tok_i.done;
  assign take     = open_req && !used_r && (tok_i.func == FUNC_ALLOC);
  assign hit      = open_req && used_r && (id_r == tok_i.sem_id) &&
                    (tok_i.func != FUNC_ALLOC);

  // Slot update and token marking
  always_comb begin
    used_nxt     = used_r;
    released_nxt = released_r;
    id_nxt       = id_r;
    tok_nxt      = tok_i;
    if (take) begin
      used_nxt     = 1'b1;
      released_nxt = 1'b1;
      id_nxt       = tok_i.alloc_id;
      tok_nxt.done = 1'b1;
    end else if (hit) begin
      tok_nxt.done = 1'b1;
      unique case (tok_i.func)
        FUNC_FREE: begin
          used_nxt     = 1'b0;
          released_nxt = 1'b0;
          id_nxt       = '0;
        end
        FUNC_DOWN: begin
          if (released_r) begin
            released_nxt = 1'b0;
          end else begin
            tok_nxt.status = ST_BUSY;
          end
        end
        FUNC_UP: begin
          released_nxt = 1'b1;
        end
        FUNC_ALLOC: begin
          // not reachable: hit excludes alloc
        end
        default: begin
        end
      endcase
    end
  end

  // Slot state and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= 1'b0;
      released_r <= 1'b0;
      tok_r      <= '0;
    end else begin
      used_r     <= used_nxt;
      released_r <= released_nxt;
      tok_r      <= tok_nxt;
    end
  end

  // Id is only compared while the slot is used
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign tok_o = tok_r;

endmodule
